>>> hdl/servo_motion_output_arbiter_macros.svh
// assertion macros for the servo motion output arbiter
// included by the top level; expects clk and rst in scope
`ifndef SERVO_MOTION_OUTPUT_ARBITER_MACROS_SVH
`define SERVO_MOTION_OUTPUT_ARBITER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SMOA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SMOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/smoa_pkg.sv
// shared types, codes and field layouts for the servo motion output arbiter
// no dependencies; used by smoa_step and servo_motion_output_arbiter
package smoa_pkg;

  localparam int ReqTypeW   = 3;
  localparam int VelW       = 32;
  localparam int PosW       = 32;
  localparam int TmoW       = 31;
  localparam int CmdIdW     = 64;
  localparam int RateW      = 31;
  localparam int CmdKindW   = 2;
  localparam int InDataW    = 200;
  localparam int OutDataW   = 104;
  localparam int CfgIndexW  = 1;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_ACCEL = 1'd0;
  localparam logic [CfgIndexW-1:0] REG_DECEL = 1'd1;

  // request types
  localparam logic [2:0] REQ_NONE       = 3'd0;
  localparam logic [2:0] REQ_JOG        = 3'd1;
  localparam logic [2:0] REQ_VELOCITY   = 3'd2;
  localparam logic [2:0] REQ_MOVE_FORCE = 3'd3;
  localparam logic [2:0] REQ_HOLD_FORCE = 3'd4;
  localparam logic [2:0] REQ_ABSOLUTE   = 3'd5;
  localparam logic [2:0] REQ_INCREMENT  = 3'd6;

  // servo command types as reported by the snapshot
  localparam logic [1:0] SERVO_VELOCITY = 2'd1;
  localparam logic [1:0] SERVO_MOVE     = 2'd2;
  localparam logic [1:0] SERVO_STOP     = 2'd3;

  // servo command states
  localparam logic [2:0] CST_COMPLETED = 3'd1;
  localparam logic [2:0] CST_ERROR     = 3'd2;
  localparam logic [2:0] CST_TIMEOUT   = 3'd3;
  localparam logic [2:0] CST_STOPPED   = 3'd4;

  // command issued this tick
  localparam logic [CmdKindW-1:0] CMD_NONE     = 2'd0;
  localparam logic [CmdKindW-1:0] CMD_VELOCITY = 2'd1;
  localparam logic [CmdKindW-1:0] CMD_MOVE     = 2'd2;
  localparam logic [CmdKindW-1:0] CMD_STOP     = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_VEL       = 3'd1,
    MODE_POS       = 3'd2,
    MODE_STOP_REV  = 3'd3,
    MODE_STOPPING  = 3'd4,
    MODE_STOPPED   = 3'd5
  } mode_t;

  typedef struct packed {
    mode_t                      mode;
    logic [ReqTypeW-1:0]        active_type;
    logic signed [VelW-1:0]     active_velocity;
    logic signed [PosW-1:0]     active_position;
    logic [CmdIdW-1:0]          id_before_issue;
    logic                       observed;
    logic signed [VelW-1:0]     last_tried_velocity;
    logic signed [PosW-1:0]     last_tried_position;
    logic                       stop_latched;
    logic                       hold_one_tick;
  } arb_state_t;

  typedef struct packed {
    logic [ReqTypeW-1:0]        req_type;
    logic signed [VelW-1:0]     target_velocity;
    logic signed [PosW-1:0]     target_position;
    logic signed [VelW-1:0]     profile_velocity;
    logic [TmoW-1:0]            timeout_ms;
    logic                       force_stop;
    logic                       rearm_stop;
    logic                       servo_read_valid;
    logic [CmdIdW-1:0]          servo_cmd_id;
    logic [1:0]                 servo_cmd_type;
    logic [2:0]                 servo_cmd_state;
    logic                       engine_accept;
  } req_item_t;

  typedef struct packed {
    logic [CmdKindW-1:0]        cmd_kind;
    logic signed [VelW-1:0]     cmd_velocity;
    logic signed [PosW-1:0]     cmd_position;
    logic [TmoW-1:0]            cmd_timeout;
    logic [2:0]                 out_state;
    logic                       motion_active;
    logic                       stop_complete;
    logic [ReqTypeW-1:0]        active_kind;
    logic                       command_seen;
  } res_item_t;

  function automatic logic is_positive(input logic signed [VelW-1:0] v);
    return (v != '0) && !v[VelW-1];
  endfunction

endpackage

>>> hdl/smoa_step.sv
// one control tick of the arbiter: next state and result from current state
// and one request item; purely combinational, uses smoa_pkg
module smoa_step (
  input  smoa_pkg::arb_state_t cur,
  input  smoa_pkg::req_item_t  item,
  output smoa_pkg::arb_state_t nxt,
  output smoa_pkg::res_item_t  res
);
  import smoa_pkg::*;

  logic want_v;
  logic want_p;
  logic stop_done;
  logic latched;
  logic id_changed;
  logic obs;
  logic pos_done;
  logic pos_same;
  logic term_state;
  logic [CmdKindW-1:0]    kind;
  logic signed [VelW-1:0] o_vel;
  logic signed [PosW-1:0] o_pos;
  logic [TmoW-1:0]        o_tmo;

  always_comb begin
    want_v = (item.req_type >= REQ_JOG) && (item.req_type <= REQ_HOLD_FORCE) &&
             (item.target_velocity != '0);
    want_p = (item.req_type == REQ_ABSOLUTE) || (item.req_type == REQ_INCREMENT);
    stop_done = item.servo_read_valid && (item.servo_cmd_type == SERVO_STOP) &&
                (item.servo_cmd_state == CST_STOPPED);
    latched = cur.stop_latched && !item.rearm_stop;
    id_changed = item.servo_read_valid && (item.servo_cmd_id != cur.id_before_issue);
    obs = cur.observed ||
          ((cur.mode == MODE_VEL) && id_changed && (item.servo_cmd_type == SERVO_VELOCITY)) ||
          ((cur.mode == MODE_POS) && id_changed && (item.servo_cmd_type == SERVO_MOVE));
    term_state = (item.servo_cmd_state == CST_COMPLETED) ||
                 (item.servo_cmd_state == CST_ERROR) ||
                 (item.servo_cmd_state == CST_TIMEOUT);
    pos_done = (cur.mode == MODE_POS) && obs && term_state;
    pos_same = (cur.mode == MODE_POS) && want_p &&
               (cur.active_position == item.target_position);

    nxt   = cur;
    kind  = CMD_NONE;
    o_vel = '0;
    o_pos = '0;
    o_tmo = '0;

    if (item.force_stop) begin
      nxt.stop_latched = 1'b1;
      if (!latched) begin
        // first tick of a force-stop: issue the stop
        kind = CMD_STOP;
        nxt.mode = MODE_STOPPING;
        nxt.active_type = '0;
        nxt.active_velocity = '0;
        nxt.active_position = '0;
      end else if (stop_done) begin
        nxt.mode = MODE_IDLE;
        nxt.active_type = '0;
        nxt.active_velocity = '0;
        nxt.active_position = '0;
        nxt.id_before_issue = '0;
        nxt.observed = 1'b0;
      end
    end else begin
      nxt.stop_latched = 1'b0;
      nxt.observed = obs;
      if ((cur.mode == MODE_STOP_REV) || (cur.mode == MODE_STOPPING)) begin
        if (stop_done) begin
          nxt.mode = MODE_IDLE;
          nxt.active_type = '0;
          nxt.active_velocity = '0;
          nxt.active_position = '0;
          nxt.id_before_issue = '0;
          nxt.observed = 1'b0;
          nxt.last_tried_velocity = '0;
          nxt.last_tried_position = '0;
          nxt.hold_one_tick = 1'b1;
        end
      end else if (pos_done) begin
        nxt.mode = MODE_STOPPED;
      end else if (pos_same) begin
        // already moving to this target
      end else if (!want_v && !want_p) begin
        if ((cur.mode == MODE_VEL) || (cur.mode == MODE_POS)) begin
          kind = CMD_STOP;
          nxt.mode = MODE_STOPPING;
          nxt.active_type = '0;
          nxt.active_velocity = '0;
          nxt.active_position = '0;
        end
        nxt.last_tried_velocity = '0;
      end else if (cur.hold_one_tick) begin
        nxt.hold_one_tick = 1'b0;
      end else if (want_v && (cur.mode == MODE_VEL) &&
                   (is_positive(cur.active_velocity) != is_positive(item.target_velocity))) begin
        // direction reversal: stop first
        kind = CMD_STOP;
        nxt.mode = MODE_STOP_REV;
        nxt.active_type = '0;
        nxt.active_velocity = '0;
        nxt.active_position = '0;
        nxt.last_tried_velocity = '0;
      end else if (want_v && (cur.mode == MODE_VEL) &&
                   (cur.active_velocity == item.target_velocity)) begin
        // same velocity already running
      end else if (want_p) begin
        if (cur.last_tried_position != item.target_position) begin
          nxt.last_tried_position = item.target_position;
          kind  = CMD_MOVE;
          o_vel = item.profile_velocity;
          o_pos = item.target_position;
          o_tmo = item.timeout_ms;
          if (item.engine_accept) begin
            nxt.mode = MODE_POS;
            nxt.active_type = item.req_type;
            nxt.active_position = item.target_position;
            nxt.active_velocity = '0;
            nxt.id_before_issue = item.servo_cmd_id;
            nxt.observed = 1'b0;
          end
        end
      end else if (cur.last_tried_velocity != item.target_velocity) begin
        nxt.last_tried_velocity = item.target_velocity;
        kind  = CMD_VELOCITY;
        o_vel = item.target_velocity;
        if (item.engine_accept) begin
          nxt.mode = MODE_VEL;
          nxt.active_type = item.req_type;
          nxt.active_velocity = item.target_velocity;
          nxt.active_position = '0;
          nxt.id_before_issue = item.servo_cmd_id;
          nxt.observed = 1'b0;
        end
      end
    end

    res.cmd_kind      = kind;
    res.cmd_velocity  = o_vel;
    res.cmd_position  = o_pos;
    res.cmd_timeout   = o_tmo;
    res.out_state     = nxt.mode;
    res.motion_active = (nxt.mode == MODE_VEL) || (nxt.mode == MODE_POS);
    res.stop_complete = (nxt.mode == MODE_STOPPED);
    res.active_kind   = nxt.active_type;
    res.command_seen  = nxt.observed;
  end

endmodule

>>> hdl/servo_motion_output_arbiter.sv
// a request passes the input register and then the output register to m_tvalid
// one transaction per cycle unless m_tready stalls, set by single-pass tick logic
// reset (rst, synchronous, active high) empties both registers, returns the
// arbiter state to idle with all tracked values zero and clears both ramp rates
// top level of the servo motion output arbiter; uses smoa_pkg, smoa_step
// and the assertion macros header
`include "servo_motion_output_arbiter_macros.svh"

module servo_motion_output_arbiter #(
  parameter int RATE_W = smoa_pkg::RateW
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // target_velocity, target_position, profile_velocity, timeout_ms, force_stop,
  // rearm_stop, servo_read_valid, servo_cmd_id, servo_cmd_type,
  // servo_cmd_state, engine_accept
  input  logic [smoa_pkg::InDataW-1:0]  s_tdata,
  // req_type
  input  logic [smoa_pkg::ReqTypeW-1:0] s_tuser,
  // result channel
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // cmd_velocity, cmd_position, cmd_timeout, out_state, motion_active,
  // stop_complete, active_kind, command_seen
  output logic [smoa_pkg::OutDataW-1:0] m_tdata,
  // cmd_kind
  output logic [smoa_pkg::CmdKindW-1:0] m_tuser,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [smoa_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [RATE_W-1:0]             cfg_data
);
  import smoa_pkg::*;

  // ramp rates, held for the servo command interface
  logic [RATE_W-1:0] accel_rate;
  logic [RATE_W-1:0] decel_rate;

  // input register
  logic                in_valid;
  logic [InDataW-1:0]  in_data;
  logic [ReqTypeW-1:0] in_user;

  // arbiter state, advanced once per tick
  arb_state_t state;
  arb_state_t state_next;

  req_item_t item;
  res_item_t res;

  logic advance;

  // an item leaves the input register when the output register is free or
  // its current transaction is being taken this cycle
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // unpack the request fields, lowest bit first
  always_comb begin
    item.req_type         = in_user;
    item.target_velocity  = in_data[31:0];
    item.target_position  = in_data[63:32];
    item.profile_velocity = in_data[95:64];
    item.timeout_ms       = in_data[126:96];
    item.force_stop       = in_data[127];
    item.rearm_stop       = in_data[128];
    item.servo_read_valid = in_data[129];
    item.servo_cmd_id     = in_data[193:130];
    item.servo_cmd_type   = in_data[195:194];
    item.servo_cmd_state  = in_data[198:196];
    item.engine_accept    = in_data[199];
  end

  smoa_step u_step (
    .cur  (state),
    .item (item),
    .nxt  (state_next),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_rate <= '0;
      decel_rate <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL: accel_rate <= cfg_data;
        REG_DECEL: decel_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_user <= s_tuser;
    end
  end

  // arbiter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= res.cmd_kind;
      m_tdata <= {res.command_seen, res.active_kind,
                  res.stop_complete, res.motion_active, res.out_state,
                  res.cmd_timeout, res.cmd_position, res.cmd_velocity};
    end
  end

  // an item taken from the input register always lands in the output register
  `SMOA_ASSERT_NEXT(a_result_follows, advance, m_tvalid, "result lost after advance")
  // the state only moves when a tick is processed
  `SMOA_ASSERT_NEXT(a_state_holds, !advance, $stable(state), "state changed without a tick")
  // idle never jumps straight to stopped or to a reversal stop
  `SMOA_ASSERT_NEXT(a_idle_exit, advance && (state.mode == MODE_IDLE),
    (state.mode != MODE_STOPPED) && (state.mode != MODE_STOP_REV),
    "illegal exit from idle")
  // a force-stop tick never issues a velocity or move command
  `SMOA_ASSERT_NOW(a_force_no_motion, advance && item.force_stop,
    (res.cmd_kind == CMD_NONE) || (res.cmd_kind == CMD_STOP),
    "motion command during force-stop")

endmodule

>>> bench/servo_motion_output_arbiter_test.sv
`timescale 1ns / 1ps
// self-checking bench for servo_motion_output_arbiter: directed ticks, then random
// command sequences, checked field by field against an in-bench tick predictor
// depends on smoa_pkg and the arbiter top level only

module servo_motion_output_arbiter_test;
  import smoa_pkg::*;

  // codes with no name in the package
  localparam logic [2:0] REQ_OTHER   = 3'd7;
  localparam logic [1:0] SERVO_OTHER = 2'd0;
  localparam logic [2:0] CST_OTHER   = 3'd0;
  localparam int         DrainPause  = 4;

  // tracks the arbiter state tick by tick and holds the expected result transactions
  class command_scoreboard;
    mode_t          mode;
    logic [2:0]     act_type;
    logic [31:0]    act_vel;
    logic [31:0]    act_pos;
    logic [63:0]    issue_id;
    logic           seen;
    logic [31:0]    tried_vel;
    logic [31:0]    tried_pos;
    logic           stop_held;
    logic           settle_tick;
    logic [30:0]    accel;
    logic [30:0]    decel;
    res_item_t      expected_ticks[$];
    int             errors;

    function new();
      mode        = MODE_IDLE;
      act_type    = '0;
      act_vel     = '0;
      act_pos     = '0;
      issue_id    = '0;
      seen        = 1'b0;
      tried_vel   = '0;
      tried_pos   = '0;
      stop_held   = 1'b0;
      settle_tick = 1'b0;
      accel       = '0;
      decel       = '0;
      errors      = 0;
    endfunction

    // ramp rates are only held, no result field shows them
    function void note_rate(input logic [CfgIndexW-1:0] idx, input logic [30:0] value);
      if (idx == REG_ACCEL) accel = value;
      else if (idx == REG_DECEL) decel = value;
    endfunction

    function logic heads_forward(input logic [31:0] v);
      return (v != '0) && !v[31];
    endfunction

    function void clear_motion();
      mode     = MODE_IDLE;
      act_type = '0;
      act_vel  = '0;
      act_pos  = '0;
      issue_id = '0;
      seen     = 1'b0;
    endfunction

    function void begin_stop(input mode_t next, inout res_item_t e);
      e.cmd_kind = CMD_STOP;
      mode       = next;
      act_type   = '0;
      act_vel    = '0;
      act_pos    = '0;
    endfunction

    function void predict_tick(input req_item_t r, inout res_item_t e);
      logic want_v;
      logic want_p;
      logic halted;
      want_v = (r.req_type >= REQ_JOG) && (r.req_type <= REQ_HOLD_FORCE) &&
               (r.target_velocity != '0);
      want_p = (r.req_type == REQ_ABSOLUTE) || (r.req_type == REQ_INCREMENT);
      halted = r.servo_read_valid && (r.servo_cmd_type == SERVO_STOP) &&
               (r.servo_cmd_state == CST_STOPPED);

      if (r.rearm_stop) stop_held = 1'b0;
      // a force-stop issues one stop, then only waits for the servo to halt
      if (r.force_stop) begin
        if (!stop_held) begin
          begin_stop(MODE_STOPPING, e);
          stop_held = 1'b1;
          return;
        end
        if (halted) clear_motion();
        return;
      end
      stop_held = 1'b0;

      if (mode == MODE_VEL && r.servo_read_valid && r.servo_cmd_id != issue_id &&
          r.servo_cmd_type == SERVO_VELOCITY)
        seen = 1'b1;

      if (mode == MODE_STOP_REV || mode == MODE_STOPPING) begin
        if (!halted) return;
        clear_motion();
        tried_vel   = '0;
        tried_pos   = '0;
        settle_tick = 1'b1;
        return;
      end

      if (mode == MODE_POS) begin
        if (r.servo_read_valid && r.servo_cmd_id != issue_id &&
            r.servo_cmd_type == SERVO_MOVE)
          seen = 1'b1;
        if (seen && (r.servo_cmd_state == CST_COMPLETED || r.servo_cmd_state == CST_ERROR ||
                     r.servo_cmd_state == CST_TIMEOUT)) begin
          mode = MODE_STOPPED;
          return;
        end
        if (want_p && act_pos == r.target_position) return;
      end

      if (!want_v && !want_p) begin
        if (mode == MODE_VEL || mode == MODE_POS) begin_stop(MODE_STOPPING, e);
        tried_vel = '0;
        return;
      end

      if (settle_tick) begin
        settle_tick = 1'b0;
        return;
      end

      if (want_v && mode == MODE_VEL) begin
        if (heads_forward(act_vel) != heads_forward(r.target_velocity)) begin
          begin_stop(MODE_STOP_REV, e);
          tried_vel = '0;
          return;
        end
        if (act_vel == r.target_velocity) return;
      end

      if (want_p) begin
        if (tried_pos == r.target_position) return;
        tried_pos      = r.target_position;
        e.cmd_kind     = CMD_MOVE;
        e.cmd_velocity = r.profile_velocity;
        e.cmd_position = r.target_position;
        e.cmd_timeout  = r.timeout_ms;
        // a rejected move is still reported and still counts as tried
        if (r.engine_accept) begin
          mode     = MODE_POS;
          act_type = r.req_type;
          act_pos  = r.target_position;
          act_vel  = '0;
          issue_id = r.servo_cmd_id;
          seen     = 1'b0;
        end
        return;
      end

      if (tried_vel == r.target_velocity) return;
      tried_vel      = r.target_velocity;
      e.cmd_kind     = CMD_VELOCITY;
      e.cmd_velocity = r.target_velocity;
      if (r.engine_accept) begin
        mode     = MODE_VEL;
        act_type = r.req_type;
        act_vel  = r.target_velocity;
        act_pos  = '0;
        issue_id = r.servo_cmd_id;
        seen     = 1'b0;
      end
    endfunction

    function void note_request(input req_item_t r);
      res_item_t e;
      e = '0;
      predict_tick(r, e);
      e.out_state     = mode;
      e.motion_active = (mode == MODE_VEL) || (mode == MODE_POS);
      e.stop_complete = (mode == MODE_STOPPED);
      e.active_kind   = act_type;
      e.command_seen  = seen;
      expected_ticks.push_back(e);
    endfunction

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      if (errors <= 100)
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task check_result(input res_item_t got);
      res_item_t want;
      if (expected_ticks.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(got.cmd_kind), '0);
        return;
      end
      want = expected_ticks.pop_front();
      if (got.cmd_kind != want.cmd_kind)
        report_mismatch("cmd_kind", 64'(got.cmd_kind), 64'(want.cmd_kind));
      if (got.cmd_velocity != want.cmd_velocity)
        report_mismatch("cmd_velocity", 64'(got.cmd_velocity), 64'(want.cmd_velocity));
      if (got.cmd_position != want.cmd_position)
        report_mismatch("cmd_position", 64'(got.cmd_position), 64'(want.cmd_position));
      if (got.cmd_timeout != want.cmd_timeout)
        report_mismatch("cmd_timeout", 64'(got.cmd_timeout), 64'(want.cmd_timeout));
      if (got.out_state != want.out_state)
        report_mismatch("out_state", 64'(got.out_state), 64'(want.out_state));
      if (got.motion_active != want.motion_active)
        report_mismatch("motion_active", 64'(got.motion_active), 64'(want.motion_active));
      if (got.stop_complete != want.stop_complete)
        report_mismatch("stop_complete", 64'(got.stop_complete), 64'(want.stop_complete));
      if (got.active_kind != want.active_kind)
        report_mismatch("active_kind", 64'(got.active_kind), 64'(want.active_kind));
      if (got.command_seen != want.command_seen)
        report_mismatch("command_seen", 64'(got.command_seen), 64'(want.command_seen));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // target_velocity, target_position, profile_velocity, timeout_ms, force_stop,
  // rearm_stop, servo_read_valid, servo_cmd_id, servo_cmd_type, servo_cmd_state,
  // engine_accept
  logic [InDataW-1:0]    s_tdata = '0;
  // req_type
  logic [ReqTypeW-1:0]   s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // cmd_velocity, cmd_position, cmd_timeout, out_state, motion_active,
  // stop_complete, active_kind, command_seen
  logic [OutDataW-1:0]   m_tdata;
  // cmd_kind
  logic [CmdKindW-1:0]   m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CfgIndexW-1:0]  cfg_index = '0;
  logic [RateW-1:0]      cfg_data = '0;

  command_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // request that the random sequences keep repeating until they change it
  logic [2:0]  cur_rt = REQ_NONE;
  logic [31:0] cur_tv = '0;
  logic [31:0] cur_tp = '0;
  logic [31:0] cur_pv = '0;
  logic [30:0] cur_tmo = '0;
  int          force_left = 0;
  logic [63:0] dir_id = 64'd1;

  servo_motion_output_arbiter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor: unpack the transaction and hand it to the scoreboard
  always @(posedge clk) begin
    res_item_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.cmd_kind      = m_tuser;
      got.cmd_velocity  = m_tdata[31:0];
      got.cmd_position  = m_tdata[63:32];
      got.cmd_timeout   = m_tdata[94:64];
      got.out_state     = m_tdata[97:95];
      got.motion_active = m_tdata[98];
      got.stop_complete = m_tdata[99];
      got.active_kind   = m_tdata[102:100];
      got.command_seen  = m_tdata[103];
      sb.check_result(got);
    end
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // entered and left at a falling edge; valid stays up for back-to-back transactions
  task automatic push_request(input req_item_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.req_type;
    s_tdata  <= {r.engine_accept, r.servo_cmd_state, r.servo_cmd_type, r.servo_cmd_id,
                 r.servo_read_valid, r.rearm_stop, r.force_stop, r.timeout_ms,
                 r.profile_velocity, r.target_position, r.target_velocity};
    do @(posedge clk); while (!s_tready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // drop valid and wait until every expected result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.expected_ticks.size() != 0);
  endtask

  task automatic write_rate(input logic [CfgIndexW-1:0] idx, input logic [RateW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.note_rate(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // block idle, then both ramp rates rewritten
  task automatic retune(input logic [RateW-1:0] accel, input logic [RateW-1:0] decel);
    drain_results();
    repeat (DrainPause) @(negedge clk);
    write_rate(REG_ACCEL, accel);
    write_rate(REG_DECEL, decel);
  endtask

  task automatic send_dir(input logic [2:0] rt, input logic [31:0] tv, input logic [31:0] tp,
                          input logic fs, input logic ra, input logic rd,
                          input logic [1:0] ctype, input logic [2:0] cstate, input logic acc);
    req_item_t r;
    r.req_type         = rt;
    r.target_velocity  = tv;
    r.target_position  = tp;
    r.profile_velocity = $urandom;
    r.timeout_ms       = 31'($urandom);
    r.force_stop       = fs;
    r.rearm_stop       = ra;
    r.servo_read_valid = rd;
    r.servo_cmd_id     = dir_id;
    r.servo_cmd_type   = ctype;
    r.servo_cmd_state  = cstate;
    r.engine_accept    = acc;
    dir_id++;
    push_request(r);
  endtask

  function automatic logic [31:0] pick_velocity();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'd1;
      2: return 32'hffff_ffff;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0000;
      5: return 32'($urandom_range(1, 1000));
      6: return -32'($urandom_range(1, 1000));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_position();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      5: return $urandom;
      default: return 32'($urandom_range(0, 15)) * 32'd1000;
    endcase
  endfunction

  // mostly coherent request sequences with servo snapshots that follow the
  // predicted state, plus some fully random noise
  function automatic req_item_t next_random_request();
    req_item_t r;
    int roll;
    r = '0;
    if ($urandom_range(99) < 12) begin
      r.req_type         = 3'($urandom);
      r.target_velocity  = $urandom;
      r.target_position  = $urandom;
      r.profile_velocity = $urandom;
      r.timeout_ms       = 31'($urandom);
      r.force_stop       = ($urandom_range(99) < 10);
      r.rearm_stop       = 1'($urandom);
      r.servo_read_valid = 1'($urandom);
      r.servo_cmd_id     = {$urandom, $urandom};
      r.servo_cmd_type   = 2'($urandom);
      r.servo_cmd_state  = 3'($urandom);
      r.engine_accept    = 1'($urandom);
      return r;
    end

    if ($urandom_range(99) < 20) begin
      roll = $urandom_range(99);
      if (roll < 12) cur_rt = REQ_NONE;
      else if (roll < 55) cur_rt = 3'($urandom_range(REQ_JOG, REQ_HOLD_FORCE));
      else if (roll < 90) cur_rt = $urandom_range(1) ? REQ_ABSOLUTE : REQ_INCREMENT;
      else cur_rt = REQ_OTHER;
      cur_tv  = pick_velocity();
      cur_tp  = pick_position();
      cur_pv  = $urandom;
      cur_tmo = 31'($urandom);
    end else if ($urandom_range(99) < 15) begin
      cur_tv = pick_velocity();
    end else if ($urandom_range(99) < 8) begin
      cur_tp = pick_position();
    end
    r.req_type         = cur_rt;
    r.target_velocity  = cur_tv;
    r.target_position  = cur_tp;
    r.profile_velocity = cur_pv;
    r.timeout_ms       = cur_tmo;

    // force-stop comes in short held bursts
    if (force_left > 0) begin
      r.force_stop = 1'b1;
      force_left--;
    end else if ($urandom_range(99) < 4) begin
      r.force_stop = 1'b1;
      force_left   = $urandom_range(0, 4);
    end
    r.rearm_stop = ($urandom_range(99) < 6);

    r.servo_read_valid = ($urandom_range(99) < 85);
    r.servo_cmd_id     = ($urandom_range(99) < 50) ? sb.issue_id + 64'd1 : sb.issue_id;
    r.servo_cmd_type   = 2'($urandom);
    r.servo_cmd_state  = 3'($urandom);
    case (sb.mode)
      MODE_STOP_REV, MODE_STOPPING: begin
        if ($urandom_range(99) < 45) begin
          r.servo_cmd_type  = SERVO_STOP;
          r.servo_cmd_state = CST_STOPPED;
        end
      end
      MODE_VEL: begin
        if ($urandom_range(99) < 50) r.servo_cmd_type = SERVO_VELOCITY;
      end
      MODE_POS: begin
        if ($urandom_range(99) < 50) r.servo_cmd_type = SERVO_MOVE;
        roll = $urandom_range(99);
        if (roll < 25) r.servo_cmd_state = 3'($urandom_range(CST_COMPLETED, CST_TIMEOUT));
        else if (roll < 35) r.servo_cmd_state = 3'($urandom_range(5, 7));
        else r.servo_cmd_state = $urandom_range(1) ? CST_OTHER : CST_STOPPED;
      end
      default: ;
    endcase
    r.engine_accept = ($urandom_range(99) < 85);
    return r;
  endfunction

  task automatic run_phase(input int count, input int send_pct, input int stall_pct,
                           input int pause_at);
    req_item_t r;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) begin
      // sender holds off until the block has nothing left in flight
      if (k == pause_at) drain_results();
      r = next_random_request();
      push_request(r);
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_rate(REG_ACCEL, '0);
    write_rate(REG_DECEL, '1);

    // quiet tick, then a positive jog that is accepted
    send_dir(REQ_NONE, '0, '0, 0, 0, 0, SERVO_OTHER, CST_OTHER, 1);
    send_dir(REQ_JOG, 32'd5, '0, 0, 0, 1, SERVO_OTHER, CST_OTHER, 1);
    // same jog again is not repeated; servo then reports the velocity command
    send_dir(REQ_JOG, 32'd5, '0, 0, 0, 1, SERVO_OTHER, CST_OTHER, 1);
    send_dir(REQ_JOG, 32'd5, '0, 0, 0, 1, SERVO_VELOCITY, CST_OTHER, 1);
    // direction reversal: stop first, wait for the halt, one idle tick, then reissue
    send_dir(REQ_VELOCITY, -32'd5, '0, 0, 0, 1, SERVO_OTHER, CST_OTHER, 1);
    send_dir(REQ_VELOCITY, -32'd5, '0, 0, 0, 1, SERVO_STOP, CST_OTHER, 1);
    send_dir(REQ_VELOCITY, -32'd5, '0, 0, 0, 1, SERVO_STOP, CST_STOPPED, 1);
    send_dir(REQ_VELOCITY, -32'd5, '0, 0, 0, 1, SERVO_OTHER, CST_OTHER, 1);
    send_dir(REQ_VELOCITY, -32'd5, '0, 0, 0, 1, SERVO_OTHER, CST_OTHER, 1);
    // zero velocity asks for no motion, so the arbiter stops
    send_dir(REQ_VELOCITY, '0, '0, 0, 0, 1, SERVO_OTHER, CST_OTHER, 1);
    send_dir(REQ_VELOCITY, '0, '0, 0, 0, 1, SERVO_STOP, CST_STOPPED, 1);
    // unknown request type carries no motion even with a velocity
    send_dir(REQ_OTHER, 32'h7fff_ffff, '0, 0, 0, 1, SERVO_OTHER, CST_OTHER, 1);
    // move to the top position waits out the idle tick, then is issued and accepted
    send_dir(REQ_ABSOLUTE, '0, 32'h7fff_ffff, 0, 0, 1, SERVO_OTHER, CST_OTHER, 0);
    send_dir(REQ_ABSOLUTE, '0, 32'h7fff_ffff, 0, 0, 1, SERVO_OTHER, CST_OTHER, 1);
    // incremental taken as an absolute target, id captured with no valid snapshot
    send_dir(REQ_INCREMENT, '0, 32'h8000_0000, 0, 0, 0, SERVO_OTHER, CST_OTHER, 1);
    // out-of-range servo state counts as other; then the move times out
    send_dir(REQ_INCREMENT, '0, 32'h8000_0000, 0, 0, 1, SERVO_MOVE, 3'd7, 1);
    send_dir(REQ_INCREMENT, '0, 32'h8000_0000, 0, 0, 1, SERVO_MOVE, CST_TIMEOUT, 1);
    // from stopped straight into a velocity command
    send_dir(REQ_HOLD_FORCE, 32'h7fff_ffff, '0, 0, 0, 1, SERVO_OTHER, CST_OTHER, 1);
    // force-stop latches once, stays quiet while held, halt clears the runtime
    send_dir(REQ_HOLD_FORCE, 32'h7fff_ffff, '0, 1, 0, 1, SERVO_OTHER, CST_OTHER, 1);
    send_dir(REQ_HOLD_FORCE, 32'h7fff_ffff, '0, 1, 0, 1, SERVO_OTHER, CST_ERROR, 1);
    send_dir(REQ_HOLD_FORCE, 32'h7fff_ffff, '0, 1, 0, 1, SERVO_STOP, CST_STOPPED, 1);
    // re-arm while still forcing issues a fresh stop
    send_dir(REQ_HOLD_FORCE, 32'h7fff_ffff, '0, 1, 1, 1, SERVO_OTHER, CST_OTHER, 1);
    // released: most negative velocity after halt and the idle tick
    send_dir(REQ_MOVE_FORCE, 32'h8000_0000, '0, 0, 0, 1, SERVO_STOP, CST_STOPPED, 1);
    send_dir(REQ_MOVE_FORCE, 32'h8000_0000, '0, 0, 0, 1, SERVO_OTHER, CST_OTHER, 1);
    send_dir(REQ_MOVE_FORCE, 32'h8000_0000, '0, 0, 0, 1, SERVO_OTHER, CST_OTHER, 1);

    retune('1, '0);
    run_phase(185, 0, 0, 90);
    retune(RateW'($urandom), RateW'($urandom));
    run_phase(185, 83, 0, -1);
    retune(RateW'($urandom), RateW'($urandom));
    run_phase(185, 0, 83, -1);
    retune('0, '0);
    run_phase(185, 36, 36, 60);
    retune('1, '1);
    run_phase(185, 0, 0, -1);

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
